// ===== sv/ted_pkg.sv =====
// shared types and constants for the text encoding detector
package ted_pkg;

    // encoding verdict codes
    typedef logic [2:0] enc_t;
    localparam enc_t ENC_UTF8_BOM   = 3'd0;
    localparam enc_t ENC_UTF16_LE   = 3'd1;
    localparam enc_t ENC_UTF16_BE   = 3'd2;
    localparam enc_t ENC_UTF8_PLAIN = 3'd3;
    localparam enc_t ENC_ANSI       = 3'd4;

    // byte order marks
    localparam logic [7:0] BOM8_B0  = 8'hEF;
    localparam logic [7:0] BOM8_B1  = 8'hBB;
    localparam logic [7:0] BOM8_B2  = 8'hBF;
    localparam logic [7:0] BOM16_FF = 8'hFF;
    localparam logic [7:0] BOM16_FE = 8'hFE;

    // utf-8 lead and continuation classes
    localparam logic [7:0] ASCII_MAX  = 8'h7F;
    localparam logic [7:0] MASK_CONT  = 8'hC0;
    localparam logic [7:0] CODE_CONT  = 8'h80;
    localparam logic [7:0] MASK_LEAD2 = 8'hE0;
    localparam logic [7:0] CODE_LEAD2 = 8'hC0;
    localparam logic [7:0] MASK_LEAD3 = 8'hF0;
    localparam logic [7:0] CODE_LEAD3 = 8'hE0;
    localparam logic [7:0] MASK_LEAD4 = 8'hF8;
    localparam logic [7:0] CODE_LEAD4 = 8'hF0;
    localparam logic [7:0] MASK_OVERLONG = 8'hFE;

    // one input transaction as held in the input register
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       empty_file;
    } ted_item_t;

endpackage

// ===== sv/ted_scan.sv =====
// per-file scan state, utf-8 checker and verdict logic
module ted_scan import ted_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      adv,        // registered item moves to the result stage
    input  ted_item_t item,
    output enc_t      encoding    // verdict for the registered item
);

    logic [1:0] bytes_seen_reg, bytes_seen_next;
    logic [7:0] head_reg [3];
    logic [7:0] head_next [3];
    logic [1:0] pend_reg, pend_next;
    logic       invalid_reg, invalid_next;

    // state update for one byte
    always_comb begin
        bytes_seen_next = bytes_seen_reg;
        pend_next       = pend_reg;
        invalid_next    = invalid_reg;
        for (int i = 0; i < 3; i++) begin
            head_next[i] = head_reg[i];
        end
        if (!item.empty_file) begin
            // capture the head of the file
            if (bytes_seen_reg != 2'd3) begin
                for (int i = 0; i < 3; i++) begin
                    if (bytes_seen_reg == 2'(i)) begin
                        head_next[i] = item.data_byte;
                    end
                end
                bytes_seen_next = bytes_seen_reg + 2'd1;
            end
            // utf-8 classification
            if (pend_reg != 2'd0) begin
                if ((item.data_byte & MASK_CONT) != CODE_CONT) begin
                    invalid_next = 1'b1;
                end
                pend_next = pend_reg - 2'd1;
            end else if (item.data_byte <= ASCII_MAX) begin
                pend_next = 2'd0;
            end else if ((item.data_byte & MASK_LEAD2) == CODE_LEAD2) begin
                if ((item.data_byte & MASK_OVERLONG) == CODE_LEAD2) begin
                    invalid_next = 1'b1;
                end
                pend_next = 2'd1;
            end else if ((item.data_byte & MASK_LEAD3) == CODE_LEAD3) begin
                pend_next = 2'd2;
            end else if ((item.data_byte & MASK_LEAD4) == CODE_LEAD4) begin
                pend_next = 2'd3;
            end else begin
                invalid_next = 1'b1;
            end
        end
    end

    // verdict over the state including this byte
    always_comb begin
        if (bytes_seen_next == 2'd3 && head_next[0] == BOM8_B0
                && head_next[1] == BOM8_B1 && head_next[2] == BOM8_B2) begin
            encoding = ENC_UTF8_BOM;
        end else if (bytes_seen_next >= 2'd2 && head_next[0] == BOM16_FF
                && head_next[1] == BOM16_FE) begin
            encoding = ENC_UTF16_LE;
        end else if (bytes_seen_next >= 2'd2 && head_next[0] == BOM16_FE
                && head_next[1] == BOM16_FF) begin
            encoding = ENC_UTF16_BE;
        end else if (invalid_next || pend_next != 2'd0) begin
            encoding = ENC_ANSI;
        end else begin
            encoding = ENC_UTF8_PLAIN;
        end
    end

    // control state, cleared after each verdict
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_seen_reg <= 2'd0;
            pend_reg       <= 2'd0;
            invalid_reg    <= 1'b0;
        end else if (adv) begin
            if (item.last_byte) begin
                bytes_seen_reg <= 2'd0;
                pend_reg       <= 2'd0;
                invalid_reg    <= 1'b0;
            end else begin
                bytes_seen_reg <= bytes_seen_next;
                pend_reg       <= pend_next;
                invalid_reg    <= invalid_next;
            end
        end
    end

    // head bytes, only read once written for the current file
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                head_reg[i] <= head_next[i];
            end
        end
    end

endmodule

// ===== sv/text_encoding_detector_core.sv =====
// top level: input register, scan stage and result register
//
//  channel | ports                              | carries
//  --------+------------------------------------+---------------------------------
//  in      | s_tvalid s_tready s_tdata s_tlast  | one file byte, last, empty flag
//          | s_tuser                            |
//  out     | m_tvalid m_tready m_tdata          | encoding verdict, one per file
//
// one byte is taken per cycle while s_tready is high; the scan state update sets that rate
// a verdict is on m_tdata once the last transaction has passed the input register and the result register
// aresetn (synchronous) clears the scan control state and both valid flags
// a stalled result holds the result register; bytes keep flowing until a
// last transaction reaches the input register, then s_tready drops
module text_encoding_detector_core import ted_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // last_byte
    input  logic       s_tuser,   // empty_file
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [2:0] encoding, [7:3] zero
);

    ted_item_t item_reg;
    logic      in_valid_reg;
    logic      out_valid_reg;
    enc_t      enc_reg;
    enc_t      encoding;
    logic      adv;

    // a byte-only item always advances; a last item needs a free or draining result register
    assign adv      = in_valid_reg && (!item_reg.last_byte || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg.data_byte  <= s_tdata;
            item_reg.last_byte  <= s_tlast;
            item_reg.empty_file <= s_tuser;
        end
    end

    ted_scan u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .item     (item_reg),
        .encoding (encoding)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv && item_reg.last_byte) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && item_reg.last_byte) begin
            enc_reg <= encoding;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, enc_reg};

    // a last item moving on always leaves a verdict behind
    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && item_reg.last_byte) |=> m_tvalid)
        else $error("last item produced no verdict");

    // the verdict code stays within its defined range
    a_enc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] <= ENC_ANSI && m_tdata[7:3] == 5'd0))
        else $error("verdict code out of range");

    // input back-pressure only when both stages are full and output stalls
    a_ready_low: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a full pipeline");

    // a byte-only item never raises a new result
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid && !(adv && item_reg.last_byte)) |=> !m_tvalid)
        else $error("verdict without a last item");

endmodule

// ===== test/tb.sv =====
// testbench for the text encoding detector: directed and random files checked against a verdict predictor
`timescale 1ns / 1ps

import ted_pkg::*;

// tracks the scan state of the current file and the verdicts still owed by the block
class encoding_scoreboard;
    logic [1:0] bytes_seen;
    logic [7:0] head_bytes [3];
    logic [1:0] pending_cont;
    logic       invalid_seen;
    enc_t       expected_encodings [$];
    int         failures;

    function new();
        clear_scan();
        failures = 0;
    endfunction

    function void clear_scan();
        bytes_seen   = 2'd0;
        head_bytes[0] = 8'h00;
        head_bytes[1] = 8'h00;
        head_bytes[2] = 8'h00;
        pending_cont = 2'd0;
        invalid_seen = 1'b0;
    endfunction

    // utf-8 state update for one file byte
    function void scan_byte(logic [7:0] b);
        if (bytes_seen != 2'd3) begin
            head_bytes[bytes_seen] = b;
            bytes_seen = bytes_seen + 2'd1;
        end
        if (pending_cont != 2'd0) begin
            if ((b & MASK_CONT) != CODE_CONT)
                invalid_seen = 1'b1;
            pending_cont = pending_cont - 2'd1;
        end else if (b <= ASCII_MAX) begin
            // plain ascii
        end else if ((b & MASK_LEAD2) == CODE_LEAD2) begin
            // c0 and c1 are overlong leads
            if ((b & MASK_OVERLONG) == CODE_LEAD2)
                invalid_seen = 1'b1;
            pending_cont = 2'd1;
        end else if ((b & MASK_LEAD3) == CODE_LEAD3) begin
            pending_cont = 2'd2;
        end else if ((b & MASK_LEAD4) == CODE_LEAD4) begin
            pending_cont = 2'd3;
        end else begin
            invalid_seen = 1'b1;
        end
    endfunction

    // bom sniffing first, then the utf-8 judgement
    function enc_t judge_encoding();
        if (bytes_seen == 2'd3 && head_bytes[0] == BOM8_B0 &&
            head_bytes[1] == BOM8_B1 && head_bytes[2] == BOM8_B2)
            return ENC_UTF8_BOM;
        if (bytes_seen >= 2'd2) begin
            if (head_bytes[0] == BOM16_FF && head_bytes[1] == BOM16_FE)
                return ENC_UTF16_LE;
            if (head_bytes[0] == BOM16_FE && head_bytes[1] == BOM16_FF)
                return ENC_UTF16_BE;
        end
        if (invalid_seen || pending_cont != 2'd0)
            return ENC_ANSI;
        return ENC_UTF8_PLAIN;
    endfunction

    function void note_input(logic [7:0] b, logic last, logic empty);
        if (!empty)
            scan_byte(b);
        if (last) begin
            expected_encodings.insert(expected_encodings.size(), judge_encoding());
            clear_scan();
        end
    endfunction

    function void check_result(logic [7:0] actual);
        enc_t want;
        if (expected_encodings.size() == 0) begin
            $display("%0t: verdict with none pending, expected none, actual %0d",
                     $time, actual);
            failures++;
            return;
        end
        want = expected_encodings.pop_front();
        if (actual[2:0] != want) begin
            $display("%0t: encoding mismatch, expected %0d, actual %0d",
                     $time, want, actual[2:0]);
            failures++;
        end
        if (actual[7:3] != 5'd0) begin
            $display("%0t: padding mismatch, expected 0, actual %0d", $time, actual[7:3]);
            failures++;
        end
    endfunction

    function int outstanding();
        return expected_encodings.size();
    endfunction
endclass

module tb;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 470;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       s_tuser  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;

    int tx_idle_pct  = 22;
    int rx_idle_pct  = 47;
    int filler_pct   = 0;
    int rx_hold_left = 0;
    int items_sent   = 0;
    int cycle_count  = 0;

    logic [7:0] text_q [$];

    encoding_scoreboard sb = new();

    text_encoding_detector_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: check each transaction, then pick the next ready level
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
        if (rx_hold_left > 0) begin
            m_tready <= 1'b0;
            rx_hold_left = rx_hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // one input transaction, with random idle cycles in front
    task automatic send_item(input logic [7:0] b, input logic last, input logic empty);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        s_tuser  <= empty;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note_input(b, last, empty);
        if (!(empty && !last))
            items_sent++;
    endtask

    // whole file from text_q; optionally closed by an empty last transaction
    task automatic send_text(input bit end_empty);
        int k;
        for (k = 0; k < text_q.size(); k++) begin
            if ($urandom_range(0, 99) < filler_pct)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            send_item(text_q[k], (k == text_q.size() - 1) && !end_empty, 1'b0);
        end
        if (end_empty || text_q.size() == 0)
            send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    endtask

    function automatic logic [7:0] cont_byte();
        return 8'($urandom_range(8'h80, 8'hBF));
    endfunction

    // add one byte at the end of the file text
    task automatic add_text_byte(input logic [7:0] b);
        text_q.insert(text_q.size(), b);
    endtask

    // mostly well-formed utf-8 with random content, some boms, some damage
    task automatic build_random_text();
        int  kind;
        int  nchars;
        int  k;
        bit  noisy;
        text_q.delete();
        kind = $urandom_range(0, 99);
        if (kind < 12) begin
            text_q = {BOM8_B0, BOM8_B1, BOM8_B2};
        end else if (kind < 18) begin
            text_q = {BOM16_FF, BOM16_FE};
        end else if (kind < 24) begin
            text_q = {BOM16_FE, BOM16_FF};
        end
        nchars = $urandom_range(0, 6);
        noisy  = ($urandom_range(0, 99) < 25);
        for (k = 0; k < nchars; k++) begin
            if (noisy && $urandom_range(0, 3) == 0) begin
                add_text_byte(8'($urandom_range(0, 255)));
            end else begin
                case ($urandom_range(0, 3))
                    0: begin
                        add_text_byte(8'($urandom_range(0, 8'h7F)));
                    end
                    1: begin
                        add_text_byte(8'($urandom_range(8'hC2, 8'hDF)));
                        add_text_byte(cont_byte());
                    end
                    2: begin
                        add_text_byte(8'($urandom_range(8'hE0, 8'hEF)));
                        add_text_byte(cont_byte());
                        add_text_byte(cont_byte());
                    end
                    default: begin
                        add_text_byte(8'($urandom_range(8'hF0, 8'hF7)));
                        add_text_byte(cont_byte());
                        add_text_byte(cont_byte());
                        add_text_byte(cont_byte());
                    end
                endcase
            end
        end
        // cut the final sequence short
        if (noisy && text_q.size() > 0 && $urandom_range(0, 1) == 1)
            text_q.delete(text_q.size() - 1);
    endtask

    // hold the input side quiet until every verdict has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        int phase;
        int phase_target;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed files
        send_item(8'hFF, 1'b1, 1'b1);                     // empty file
        text_q = {BOM8_B0, BOM8_B1, BOM8_B2};  send_text(1'b0);
        text_q = {BOM16_FF, BOM16_FE};         send_text(1'b0);
        text_q = {BOM16_FE, BOM16_FF};         send_text(1'b0);
        text_q = {BOM8_B0, BOM8_B1};           send_text(1'b0);   // short utf-8 bom
        text_q = {8'hFF};                      send_text(1'b0);   // short utf-16 bom
        text_q = {8'hC0, 8'h80};               send_text(1'b0);   // overlong leads
        text_q = {8'hC1, 8'h80};               send_text(1'b0);
        // ascii, empty flag mid-file, then a three byte sequence
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b1);
        text_q = {8'hE2, 8'h82, 8'hAC};        send_text(1'b0);
        text_q = {8'hF0, 8'h9F, 8'h98, 8'h80}; send_text(1'b0);
        text_q = {8'h80};                      send_text(1'b1);   // stray continuation, empty last
        drain();

        // random files in three idling phases
        filler_pct = 5;
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct  = 22;
                    rx_idle_pct  = 47;
                    rx_hold_left = HOLD_CYCLES;
                end
                1: begin
                    tx_idle_pct = 47;
                    rx_idle_pct = 22;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            phase_target = items_sent + PHASE_ITEMS;
            while (items_sent < phase_target) begin
                build_random_text();
                send_text($urandom_range(0, 99) < 10);
            end
            drain();
        end

        if (sb.failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
